// ===== rtl/ssbm_pkg.sv =====
// Shared types and codes for the sparse shadow byte map.
`timescale 1ns / 1ps
package ssbm_pkg;

  localparam int ADDR_W = 32;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;
  localparam int BIT_W  = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_BIT    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_BIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_BIT   = 3'd4;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_READ_BYTE,
    KIND_READ_BIT,
    KIND_WRITE_BYTE,
    KIND_SET_BIT,
    KIND_CLEAR_BIT
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  write_value;
    logic [BIT_W-1:0]   bit_offset;
  } item_t;

endpackage

// ===== rtl/sparse_shadow_byte_map.sv =====
// Top level of the sparse shadow byte map: front end, item queue, access engine.
//
//   port group  dir  handshake              payload
//   in_*        in   in_valid / in_ready    operation, address, write_value, bit_offset
//   out_*       out  out_valid / out_ready  read_value, out_of_pages
//
// Each item takes a directory read, then a pool read and, for writes, a write-back that overlaps
// the next item's directory read, or a direct result when the pool is untouched.
// With the engine idle, an accepted item passes the queue, the directory read and the pool read
// before out_valid rises; the pool read is skipped when the pool is untouched.
// After reset a sweep zeroes directory and pool, one entry per cycle, with in_ready low; then
// a two-entry queue and the result register let either side stall alone.
`timescale 1ns / 1ps
module sparse_shadow_byte_map #(
  parameter int ADDR_BITS  = 32,
  parameter int PAGE_BITS  = 16,
  parameter int POOL_PAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ssbm_pkg::OP_W-1:0]     in_operation,
  input  logic [ssbm_pkg::ADDR_W-1:0]   in_address,
  input  logic [ssbm_pkg::BYTE_W-1:0]   in_write_value,
  input  logic [ssbm_pkg::BIT_W-1:0]    in_bit_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssbm_pkg::BYTE_W-1:0]   out_read_value,
  output logic                          out_out_of_pages
);

  logic            clear_done;
  logic            q_push, q_pop, q_full, q_not_empty;
  ssbm_pkg::item_t q_in_item, q_head_item;

  ssbm_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_write_value (in_write_value),
    .in_bit_offset  (in_bit_offset),
    .clear_done     (clear_done),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in_item)
  );

  ssbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ssbm_back #(
    .ADDR_BITS  (ADDR_BITS),
    .PAGE_BITS  (PAGE_BITS),
    .POOL_PAGES (POOL_PAGES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_item           (q_head_item),
    .q_pop            (q_pop),
    .clear_done       (clear_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_out_of_pages (out_out_of_pages)
  );

endmodule

// ===== rtl/ssbm_front.sv =====
// Front end: accepts input items and classifies them into queue entries.
`timescale 1ns / 1ps
module ssbm_front (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ssbm_pkg::OP_W-1:0]        in_operation,
  input  logic [ssbm_pkg::ADDR_W-1:0]      in_address,
  input  logic [ssbm_pkg::BYTE_W-1:0]      in_write_value,
  input  logic [ssbm_pkg::BIT_W-1:0]       in_bit_offset,
  input  logic                             clear_done,
  input  logic                             q_full,
  output logic                             q_push,
  output ssbm_pkg::item_t                  q_item
);

  ssbm_pkg::kind_t kind;

  always_comb begin
    case (in_operation)
      ssbm_pkg::OP_READ_BYTE:  kind = ssbm_pkg::KIND_READ_BYTE;
      ssbm_pkg::OP_WRITE_BYTE: kind = ssbm_pkg::KIND_WRITE_BYTE;
      ssbm_pkg::OP_SET_BIT:    kind = ssbm_pkg::KIND_SET_BIT;
      ssbm_pkg::OP_CLEAR_BIT:  kind = ssbm_pkg::KIND_CLEAR_BIT;
      ssbm_pkg::OP_READ_BIT:   kind = ssbm_pkg::KIND_READ_BIT;
      default:                 kind = ssbm_pkg::KIND_NOP;
    endcase
  end

  // hold off items until the memories have been swept after reset, and while the queue is full
  assign in_ready = clear_done && !q_full;
  assign q_push   = in_valid && in_ready;

  assign q_item.kind        = kind;
  assign q_item.address     = in_address;
  assign q_item.write_value = in_write_value;
  assign q_item.bit_offset  = in_bit_offset;

endmodule

// ===== rtl/ssbm_queue.sv =====
// Two-entry item queue between the front end and the access engine.
`timescale 1ns / 1ps
module ssbm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ssbm_pkg::item_t push_item,
  input  logic            pop,
  output ssbm_pkg::item_t head_item,
  output logic            not_empty,
  output logic            full
);

  ssbm_pkg::item_t                   entry_r [ssbm_pkg::QUEUE_DEPTH];
  logic [ssbm_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [ssbm_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ssbm_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == ssbm_pkg::QCNT_W'(ssbm_pkg::QUEUE_DEPTH));
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/ssbm_back.sv =====
// Access engine: page directory, page pool, allocation and result register.
`timescale 1ns / 1ps
module ssbm_back #(
  parameter int ADDR_BITS  = 32,
  parameter int PAGE_BITS  = 16,
  parameter int POOL_PAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_not_empty,
  input  ssbm_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          clear_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ssbm_pkg::BYTE_W-1:0]   out_read_value,
  output logic                          out_out_of_pages
);

  localparam int DIR_AW      = ADDR_BITS - PAGE_BITS;
  localparam int DIR_ENTRIES = 1 << DIR_AW;
  localparam int ENT_W       = $clog2(POOL_PAGES + 1);
  localparam int PG_W        = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int POOL_AW     = PG_W + PAGE_BITS;
  localparam int POOL_DEPTH  = POOL_PAGES * (1 << PAGE_BITS);
  localparam int CLR_W       = (DIR_AW > POOL_AW) ? DIR_AW : POOL_AW;

  localparam logic [ENT_W-1:0] POOL_FULL = ENT_W'(POOL_PAGES);
  localparam logic [CLR_W:0]   DIR_LIM   = (CLR_W + 1)'(DIR_ENTRIES);
  localparam logic [CLR_W:0]   POOL_LIM  = (CLR_W + 1)'(POOL_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST  = '1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR,
    ST_POOL
  } state_t;

  logic [ENT_W-1:0]            dir_mem  [DIR_ENTRIES];
  logic [ssbm_pkg::BYTE_W-1:0] pool_mem [POOL_DEPTH];

  state_t                      state_r, state_nxt;
  ssbm_pkg::item_t             cur_r, cur_nxt;
  logic [ENT_W-1:0]            pages_used_r, pages_used_nxt;
  logic [CLR_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [POOL_AW-1:0]          pool_addr_r, pool_addr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ssbm_pkg::BYTE_W-1:0] out_rv_r, out_rv_nxt;
  logic                        out_oop_r, out_oop_nxt;

  logic [ENT_W-1:0]            dir_rdata_r;
  logic [ssbm_pkg::BYTE_W-1:0] pool_rdata_r;

  logic                        dir_re, dir_we;
  logic [DIR_AW-1:0]           dir_waddr;
  logic [ENT_W-1:0]            dir_wdata;
  logic                        pool_re, pool_we;
  logic [POOL_AW-1:0]          pool_raddr, pool_waddr;
  logic [ssbm_pkg::BYTE_W-1:0] pool_wdata;

  logic                        slot_free;
  logic [DIR_AW-1:0]           cur_dir, head_dir;
  logic [PAGE_BITS-1:0]        cur_off;
  logic                        mapped, is_wr, no_access;
  logic [ENT_W-1:0]            page;
  logic [ssbm_pkg::BYTE_W-1:0] bit_mask, new_byte, rd_result;

  assign slot_free = !out_valid_r || out_ready;
  assign cur_dir   = cur_r.address[ADDR_BITS-1:PAGE_BITS];
  assign cur_off   = cur_r.address[PAGE_BITS-1:0];
  assign head_dir  = q_item.address[ADDR_BITS-1:PAGE_BITS];
  assign mapped    = (dir_rdata_r != '0) && (dir_rdata_r <= POOL_FULL);
  assign is_wr     = (cur_r.kind == ssbm_pkg::KIND_WRITE_BYTE) ||
                     (cur_r.kind == ssbm_pkg::KIND_SET_BIT) ||
                     (cur_r.kind == ssbm_pkg::KIND_CLEAR_BIT);
  // nothing to touch in the pool: unknown op, unmapped read, or no page left to map
  assign no_access = (cur_r.kind == ssbm_pkg::KIND_NOP) ||
                     (!mapped && (!is_wr || pages_used_r == POOL_FULL));
  assign page      = mapped ? dir_rdata_r - ENT_W'(1) : pages_used_r;
  assign bit_mask  = ssbm_pkg::BYTE_W'(1) << cur_r.bit_offset;

  always_comb begin
    case (cur_r.kind)
      ssbm_pkg::KIND_WRITE_BYTE: new_byte = cur_r.write_value;
      ssbm_pkg::KIND_SET_BIT:    new_byte = pool_rdata_r | bit_mask;
      ssbm_pkg::KIND_CLEAR_BIT:  new_byte = pool_rdata_r & ~bit_mask;
      default:                   new_byte = pool_rdata_r;
    endcase
    case (cur_r.kind)
      ssbm_pkg::KIND_READ_BYTE: rd_result = pool_rdata_r;
      ssbm_pkg::KIND_READ_BIT:  rd_result = {{(ssbm_pkg::BYTE_W-1){1'b0}},
                                             pool_rdata_r[cur_r.bit_offset]};
      default:                  rd_result = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    pages_used_nxt = pages_used_r;
    clr_cnt_nxt    = clr_cnt_r;
    pool_addr_nxt  = pool_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rv_nxt     = out_rv_r;
    out_oop_nxt    = out_oop_r;
    q_pop          = 1'b0;
    dir_re         = 1'b0;
    dir_we         = 1'b0;
    dir_waddr      = cur_dir;
    dir_wdata      = '0;
    pool_re        = 1'b0;
    pool_raddr     = {page[PG_W-1:0], cur_off};
    pool_we        = 1'b0;
    pool_waddr     = pool_addr_r;
    pool_wdata     = new_byte;
    case (state_r)
      ST_CLEAR: begin
        dir_we      = ({1'b0, clr_cnt_r} < DIR_LIM);
        dir_waddr   = clr_cnt_r[DIR_AW-1:0];
        pool_we     = ({1'b0, clr_cnt_r} < POOL_LIM);
        pool_waddr  = clr_cnt_r[POOL_AW-1:0];
        pool_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          dir_re    = 1'b1;
          cur_nxt   = q_item;
          state_nxt = ST_DIR;
        end
      end
      ST_DIR: begin
        if (no_access) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = '0;
            out_oop_nxt   = is_wr;
            state_nxt     = ST_IDLE;
          end
        end else begin
          if (!mapped) begin
            // take the next pool page, already zeroed by the sweep
            dir_we         = 1'b1;
            dir_wdata      = pages_used_r + 1'b1;
            pages_used_nxt = pages_used_r + 1'b1;
          end
          pool_re       = 1'b1;
          pool_addr_nxt = pool_raddr;
          state_nxt     = ST_POOL;
        end
      end
      ST_POOL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = rd_result;
          out_oop_nxt   = 1'b0;
          pool_we       = is_wr;
          // overlap the next directory lookup with this write-back
          if (q_not_empty) begin
            q_pop     = 1'b1;
            dir_re    = 1'b1;
            cur_nxt   = q_item;
            state_nxt = ST_DIR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      pages_used_r <= '0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_used_r <= pages_used_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    pool_addr_r <= pool_addr_nxt;
    out_rv_r    <= out_rv_nxt;
    out_oop_r   <= out_oop_nxt;
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (dir_re) begin
      dir_rdata_r <= dir_mem[head_dir];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    if (pool_re) begin
      pool_rdata_r <= pool_mem[pool_raddr];
    end
  end

  assign clear_done       = (state_r != ST_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_read_value   = out_rv_r;
  assign out_out_of_pages = out_oop_r;

endmodule

// ===== tb/shadow_map_checker.sv =====
// Checker for the sparse shadow byte map: predicts each result and compares it on the out channel.
`timescale 1ns / 1ps
module shadow_map_checker #(
  parameter int ADDR_BITS  = 32,
  parameter int PAGE_BITS  = 16,
  parameter int POOL_PAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ssbm_pkg::OP_W-1:0]     in_operation,
  input  logic [ssbm_pkg::ADDR_W-1:0]   in_address,
  input  logic [ssbm_pkg::BYTE_W-1:0]   in_write_value,
  input  logic [ssbm_pkg::BIT_W-1:0]    in_bit_offset,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ssbm_pkg::BYTE_W-1:0]   out_read_value,
  input  logic                          out_out_of_pages,
  output int                            mismatches,
  output int                            outstanding,
  output int                            results_seen
);

  typedef struct packed {
    logic [ssbm_pkg::BYTE_W-1:0] read_value;
    logic                        out_of_pages;
  } shadow_result_t;

  shadow_result_t              awaited_results [$];
  int unsigned                 page_slot [int unsigned];     // directory index -> pool page + 1
  logic [ssbm_pkg::BYTE_W-1:0] shadow_bytes [int unsigned];  // pool byte index -> value, absent means 0
  int unsigned                 pages_taken;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic shadow_result_t shadow_access(input logic [ssbm_pkg::OP_W-1:0] op,
                                                   input logic [ssbm_pkg::ADDR_W-1:0] addr,
                                                   input logic [ssbm_pkg::BYTE_W-1:0] wv,
                                                   input logic [ssbm_pkg::BIT_W-1:0] bo);
    shadow_result_t              res;
    logic [63:0]                 a;
    int unsigned                 page_idx;
    int unsigned                 offset;
    int unsigned                 spot;
    logic [ssbm_pkg::BYTE_W-1:0] cur;
    bit                          mapped;
    res = '0;
    a = {32'd0, addr} & ((64'd1 << ADDR_BITS) - 64'd1);
    page_idx = 32'(a >> PAGE_BITS);
    offset = 32'(a & ((64'd1 << PAGE_BITS) - 64'd1));
    mapped = page_slot.exists(page_idx);
    // every writing operation on an unmapped page takes the next pool page, or is dropped
    if (!mapped && (op == ssbm_pkg::OP_WRITE_BYTE || op == ssbm_pkg::OP_SET_BIT ||
                    op == ssbm_pkg::OP_CLEAR_BIT)) begin
      if (pages_taken >= POOL_PAGES) begin
        res.out_of_pages = 1'b1;
      end else begin
        pages_taken++;
        page_slot[page_idx] = pages_taken;
        mapped = 1'b1;
      end
    end
    if (mapped) begin
      spot = (page_slot[page_idx] - 1) * (1 << PAGE_BITS) + offset;
      cur = shadow_bytes.exists(spot) ? shadow_bytes[spot] : '0;
      case (op)
        ssbm_pkg::OP_READ_BYTE:  res.read_value = cur;
        ssbm_pkg::OP_READ_BIT:   res.read_value = {{(ssbm_pkg::BYTE_W-1){1'b0}}, cur[bo]};
        ssbm_pkg::OP_WRITE_BYTE: shadow_bytes[spot] = wv;
        ssbm_pkg::OP_SET_BIT:    shadow_bytes[spot] = cur | (8'd1 << bo);
        ssbm_pkg::OP_CLEAR_BIT:  shadow_bytes[spot] = cur & ~(8'd1 << bo);
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    shadow_result_t want;
    if (!rst_n) begin
      awaited_results.delete();
      page_slot.delete();
      shadow_bytes.delete();
      pages_taken  = 0;
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
    end else begin
      // result first: an item accepted in this cycle cannot have its result out yet
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = awaited_results.pop_front();
          if (out_read_value !== want.read_value)
            report_mismatch($sformatf("result %0d read_value %0h, expected %0h",
                                      results_seen, out_read_value, want.read_value));
          if (out_out_of_pages !== want.out_of_pages)
            report_mismatch($sformatf("result %0d out_of_pages %0b, expected %0b",
                                      results_seen, out_out_of_pages, want.out_of_pages));
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        awaited_results.push_back(shadow_access(in_operation, in_address,
                                                in_write_value, in_bit_offset));
      outstanding = awaited_results.size();
    end
  end

endmodule

// ===== tb/tb_sparse_shadow_byte_map.sv =====
// Testbench top for the sparse shadow byte map: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_sparse_shadow_byte_map;

  localparam int ADDR_BITS  = 32;
  localparam int PAGE_BITS  = 16;
  localparam int POOL_PAGES = 16;

  localparam int DIR_BITS       = ADDR_BITS - PAGE_BITS;
  localparam int POOL_SPAN_BITS = $clog2(POOL_PAGES) + PAGE_BITS;
  localparam int SWEEP_CYCLES   = 1 << ((DIR_BITS > POOL_SPAN_BITS) ? DIR_BITS : POOL_SPAN_BITS);
  localparam int WATCHDOG_LIMIT = 4 * SWEEP_CYCLES + 4096;
  localparam int DRAIN_CYCLES   = 16;

  localparam logic [ssbm_pkg::OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [ssbm_pkg::OP_W-1:0] OP_UNDEF_MID   = 3'd6;
  localparam logic [ssbm_pkg::OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 1680;
  localparam int NUM_HOT      = 24;
  localparam int PAUSE_AT     = 700;
  localparam int QUIET_FIRST  = 1000;
  localparam int QUIET_LAST   = 1300;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 120;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [ssbm_pkg::OP_W-1:0]     in_operation;
  logic [ssbm_pkg::ADDR_W-1:0]   in_address;
  logic [ssbm_pkg::BYTE_W-1:0]   in_write_value;
  logic [ssbm_pkg::BIT_W-1:0]    in_bit_offset;
  logic                          out_valid;
  logic                          out_ready;
  logic [ssbm_pkg::BYTE_W-1:0]   out_read_value;
  logic                          out_out_of_pages;

  int mismatches;
  int outstanding;
  int results_seen;
  int items_sent;
  int directed_items;
  int idle_cycles;

  sparse_shadow_byte_map #(
    .ADDR_BITS(ADDR_BITS), .PAGE_BITS(PAGE_BITS), .POOL_PAGES(POOL_PAGES)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_address(in_address),
    .in_write_value(in_write_value), .in_bit_offset(in_bit_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_out_of_pages(out_out_of_pages)
  );

  shadow_map_checker #(
    .ADDR_BITS(ADDR_BITS), .PAGE_BITS(PAGE_BITS), .POOL_PAGES(POOL_PAGES)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_address(in_address),
    .in_write_value(in_write_value), .in_bit_offset(in_bit_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_out_of_pages(out_out_of_pages),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one item from a falling edge and hold it until accepted.
  task automatic push_item(input logic [ssbm_pkg::OP_W-1:0] op,
                           input logic [ssbm_pkg::ADDR_W-1:0] addr,
                           input logic [ssbm_pkg::BYTE_W-1:0] wv,
                           input logic [ssbm_pkg::BIT_W-1:0] bo);
    bit quiet;
    quiet = (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
    while (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_address     <= addr;
    in_write_value <= wv;
    in_bit_offset  <= bo;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender
  initial begin
    int unsigned                 hot_pages [NUM_HOT];
    logic [ssbm_pkg::OP_W-1:0]   op;
    logic [ssbm_pkg::ADDR_W-1:0] addr;
    int unsigned                 offset;
    in_valid       = 1'b0;
    in_operation   = ssbm_pkg::OP_READ_BYTE;
    in_address     = '0;
    in_write_value = '0;
    in_bit_offset  = '0;
    items_sent     = 0;
    rst_n          = 1'b0;
    foreach (hot_pages[i]) hot_pages[i] = $urandom_range((1 << DIR_BITS) - 1);
    hot_pages[0] = 0;
    hot_pages[1] = (1 << DIR_BITS) - 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unmapped reads return zero
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h0000_0000, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BIT,   32'hFFFF_FFFF, 8'hFF, 3'd7);
    // first write allocates, then read it back at the field extremes
    push_item(ssbm_pkg::OP_WRITE_BYTE, 32'hFFFF_FFFF, 8'hFF, 3'd7);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'hFFFF_FFFF, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BIT,   32'hFFFF_FFFF, 8'h00, 3'd7);
    push_item(ssbm_pkg::OP_CLEAR_BIT,  32'hFFFF_FFFF, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'hFFFF_FFFF, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BIT,   32'hFFFF_FFFF, 8'h00, 3'd0);
    // clear bit on an unmapped page still allocates
    push_item(ssbm_pkg::OP_CLEAR_BIT,  32'h0000_0000, 8'h00, 3'd3);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h0000_0000, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_SET_BIT,    32'h0000_FFFF, 8'h00, 3'd7);
    push_item(ssbm_pkg::OP_READ_BIT,   32'h0000_FFFF, 8'h00, 3'd7);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h0000_FFFF, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_WRITE_BYTE, 32'h1234_5678, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h1234_5678, 8'h00, 3'd0);
    // undefined codes change nothing
    push_item(OP_UNDEF_FIRST, 32'h0000_FFFF, 8'hFF, 3'd7);
    push_item(OP_UNDEF_MID,   32'h1234_5678, 8'h5A, 3'd2);
    push_item(OP_UNDEF_LAST,  32'hFFFF_FFFF, 8'hFF, 3'd7);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h0000_FFFF, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_SET_BIT,    32'h8000_0001, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_READ_BIT,   32'h8000_0001, 8'h00, 3'd0);
    push_item(ssbm_pkg::OP_WRITE_BYTE, 32'h7FFF_0000, 8'hA5, 3'd5);
    push_item(ssbm_pkg::OP_READ_BYTE,  32'h7FFF_0000, 8'h00, 3'd0);
    directed_items = items_sent;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == PAUSE_AT) begin
        // drain everything before going on
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      if ($urandom_range(99) < 6)
        op = ssbm_pkg::OP_W'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
      else
        op = ssbm_pkg::OP_W'($urandom_range(ssbm_pkg::OP_READ_BIT, ssbm_pkg::OP_READ_BYTE));
      // mostly a small window on a few pages so reads meet earlier writes
      if ($urandom_range(99) < 10) begin
        addr = $urandom;
      end else begin
        if ($urandom_range(3) == 0)
          offset = (1 << PAGE_BITS) - 1 - $urandom_range(7);
        else
          offset = $urandom_range(15);
        addr = (hot_pages[$urandom_range(NUM_HOT - 1)] << PAGE_BITS) | offset;
      end
      push_item(op, addr, ssbm_pkg::BYTE_W'($urandom_range(255)),
                ssbm_pkg::BIT_W'($urandom_range(7)));
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d items (%0d directed, %0d random): all operations, undefined codes,",
             items_sent, directed_items, items_sent - directed_items);
    $display("pool exhaustion, random gaps, an output hold-off and a drain pause; %0d results",
             results_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("sparse_shadow_byte_map verification clean");
    end else begin
      $display("sparse_shadow_byte_map verification failed");
    end
    $finish;
  end

  // Receiver
  initial begin
    bit held;
    bit quiet;
    held = 1'b0;
    out_ready = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      @(negedge clk);
      quiet = (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST);
      if (!held && results_seen >= HOLD_AT) begin
        // hold off long enough for the block to fill and stall its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 38);
      end
    end
  end

  // Watchdog: covers the clearing sweep after reset
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles with no item moving", idle_cycles);
        $display("sparse_shadow_byte_map verification failed");
        $finish;
      end
    end
  end

endmodule
